@@ design/psfg_pkg.sv @@
package psfg_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 4;
    localparam int VALUE_W    = 11;
    localparam int CMP_W      = 8;
    localparam int CIF_W      = 4;
    localparam int IDX_W      = 5;
    localparam int TICK_W     = 16;
    localparam int FS_W       = 8;
    localparam int PULSE_W    = 14;

    localparam int CHUNK_MAX   = 255;
    localparam int END_TICKS   = 10;
    localparam int FS_CHANNELS = 5;
    localparam int FS_ADDR_W   = 3;
    localparam int FS_BIAS     = 512;

    localparam logic [CIF_W-1:0] CIF_RESET = CIF_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_EVENT    = 2'd0,
        CMD_OFFSET   = 2'd1,
        CMD_FAILSAFE = 2'd2
    } cmd_t;

    // table write request from the input channel
    typedef struct packed {
        logic                      off_we;
        logic                      fs_we;
        logic [CHAN_W-1:0]         chan;
        logic signed [VALUE_W-1:0] value;
    } tbl_wr_t;

    typedef struct packed {
        logic                 frame_restart;
        logic                 demux_reset;
        logic                 low_phase;
        logic [CMP_W-1:0]     compare_value;
    } result_t;

    function automatic logic [TICK_W-1:0] sat_add16(input logic [TICK_W-1:0] a,
                                                    input logic [TICK_W-1:0] b);
        logic [TICK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TICK_W] ? {TICK_W{1'b1}} : s[TICK_W-1:0];
    endfunction

endpackage

@@ design/psfg_tables.sv @@
module psfg_tables
    import psfg_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tbl_wr_t                   wr,
    input  logic [IDX_W-1:0]          rd_index,
    output logic signed [VALUE_W-1:0] off_data,
    output logic [FS_W-1:0]           fs_data
);

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [VALUE_W-1:0]      off_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] off_valid_reg;
    logic [FS_W-1:0]         fs_mem_reg [FS_CHANNELS];
    logic [VALUE_W-1:0]      off_rd_reg;
    logic [FS_W-1:0]         fs_rd_reg;

    logic [5:0]        wr_ext;
    logic [5:0]        rd_ext;
    logic              wr_in;
    logic              rd_in;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              off_wr;
    logic              fs_wr;
    logic              fs_rd_in;
    logic [FS_ADDR_W-1:0] fs_wr_addr;
    logic [FS_ADDR_W-1:0] fs_rd_addr;
    logic [FS_W-1:0]   fs_sat;

    assign wr_ext  = {2'b00, wr.chan};
    assign rd_ext  = {1'b0, rd_index};
    assign wr_in   = wr_ext < 6'(MAX_CHANNELS);
    assign rd_in   = rd_ext < 6'(MAX_CHANNELS);
    assign wr_addr = wr_ext[ADDR_W-1:0];
    assign rd_addr = rd_ext[ADDR_W-1:0];
    assign off_wr  = wr.off_we && wr_in;

    // failsafe entries live at channels 1..5
    assign fs_wr      = wr.fs_we && (wr.chan >= CHAN_W'(1)) && (wr.chan <= CHAN_W'(FS_CHANNELS));
    assign fs_rd_in   = (rd_index >= IDX_W'(1)) && (rd_index <= IDX_W'(FS_CHANNELS));
    assign fs_wr_addr = FS_ADDR_W'(wr.chan - CHAN_W'(1));
    assign fs_rd_addr = FS_ADDR_W'(rd_index - IDX_W'(1));

    always_comb begin
        if (wr.value < 0) begin
            fs_sat = '0;
        end else if (wr.value > VALUE_W'(255)) begin
            fs_sat = {FS_W{1'b1}};
        end else begin
            fs_sat = wr.value[FS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (off_wr) begin
            off_mem[wr_addr] <= wr.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_valid_reg <= '0;
        end else if (off_wr) begin
            off_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FS_CHANNELS; i++) begin
                fs_mem_reg[i] <= '0;
            end
        end else if (fs_wr) begin
            fs_mem_reg[fs_wr_addr] <= fs_sat;
        end
    end

    // prefetch for the index the sequencer moves to; same-cycle write forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_rd_reg <= '0;
        end else if (!rd_in) begin
            off_rd_reg <= '0;
        end else if (off_wr && (wr_addr == rd_addr)) begin
            off_rd_reg <= wr.value;
        end else if (off_valid_reg[rd_addr]) begin
            off_rd_reg <= off_mem[rd_addr];
        end else begin
            off_rd_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_rd_reg <= '0;
        end else if (!fs_rd_in) begin
            fs_rd_reg <= '0;
        end else if (fs_wr && (fs_wr_addr == fs_rd_addr)) begin
            fs_rd_reg <= fs_sat;
        end else begin
            fs_rd_reg <= fs_mem_reg[fs_rd_addr];
        end
    end

    assign off_data = $signed(off_rd_reg);
    assign fs_data  = fs_rd_reg;

endmodule

@@ design/psfg_sequencer.sv @@
module psfg_sequencer
    import psfg_pkg::*;
#(
    parameter int STOP_PULSE    = 188,
    parameter int MIN_PULSE     = 375,
    parameter int MAX_PULSE     = 1500,
    parameter int RUNTIME_GUARD = 127
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ev,
    input  logic                      fs_on,
    input  logic                      enable,
    input  logic [CIF_W-1:0]          cif,
    input  logic [TICK_W-1:0]         frame_len,
    input  logic signed [VALUE_W-1:0] off_data,
    input  logic [FS_W-1:0]           fs_data,
    output logic [IDX_W-1:0]          idx_lookahead,
    output result_t                   result
);

    localparam int CENTER      = MIN_PULSE + (MAX_PULSE - MIN_PULSE) / 2;
    localparam int GUARD_LIMIT = CHUNK_MAX + RUNTIME_GUARD;
    localparam int SHORT_CHUNK = CHUNK_MAX - RUNTIME_GUARD;

    logic              busy_reg, busy_next;
    logic              phase_low_reg, phase_low_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [TICK_W-1:0] ft_reg, ft_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              demux_reg, demux_next;

    logic [IDX_W-1:0]        idx_inc;
    logic                    fs_use;
    logic [PULSE_W-1:0]      p_raw;
    logic signed [PULSE_W-1:0] p_s;
    logic signed [PULSE_W-1:0] p_clamp;
    logic [TICK_W-1:0]       chan_ticks;
    logic [TICK_W-1:0]       gap_ticks;
    logic [TICK_W-1:0]       rem_start;
    logic [TICK_W-1:0]       rem_less;
    logic                    restart;
    logic [CMP_W-1:0]        cmp;

    assign idx_inc = idx_reg + IDX_W'(1);

    // channel pulse: center plus offset, or failsafe position, clamped
    assign fs_use = fs_on && (idx_reg >= IDX_W'(1)) && (idx_reg <= IDX_W'(FS_CHANNELS))
                    && (fs_data != '0);

    always_comb begin
        if (fs_use) begin
            p_raw = PULSE_W'(CENTER) + {{(PULSE_W-FS_W-2){1'b0}}, fs_data, 2'b00}
                    - PULSE_W'(FS_BIAS);
        end else begin
            p_raw = PULSE_W'(CENTER) + {{(PULSE_W-VALUE_W){off_data[VALUE_W-1]}}, off_data};
        end
        p_s = $signed(p_raw);
        if (p_s > $signed(PULSE_W'(MAX_PULSE))) begin
            p_clamp = $signed(PULSE_W'(MAX_PULSE));
        end else if (p_s < $signed(PULSE_W'(MIN_PULSE))) begin
            p_clamp = $signed(PULSE_W'(MIN_PULSE));
        end else begin
            p_clamp = p_s;
        end
    end

    assign chan_ticks = TICK_W'($unsigned(p_clamp - $signed(PULSE_W'(STOP_PULSE))));
    assign gap_ticks  = (frame_len > ft_reg) ? (frame_len - ft_reg) : '0;

    // phase start
    always_comb begin
        phase_low_next = phase_low_reg;
        ft_next        = ft_reg;
        idx_next       = idx_reg;
        demux_next     = demux_reg;
        rem_start      = rem_reg;
        restart        = 1'b0;
        if (ev && !busy_reg) begin
            if (phase_low_reg) begin
                phase_low_next = 1'b0;
                if (idx_reg == '0) begin
                    rem_start  = gap_ticks;
                    ft_next    = '0;
                    demux_next = 1'b1;
                end else if (idx_reg > {1'b0, cif}) begin
                    rem_start = TICK_W'(END_TICKS);
                end else begin
                    rem_start = chan_ticks;
                    ft_next   = sat_add16(ft_reg, chan_ticks);
                end
            end else begin
                phase_low_next = 1'b1;
                rem_start      = TICK_W'(STOP_PULSE);
                ft_next        = sat_add16(ft_reg, TICK_W'(STOP_PULSE));
                demux_next     = !enable;
                if (idx_inc > ({1'b0, cif} + IDX_W'(1))) begin
                    idx_next = '0;
                    restart  = 1'b1;
                end else begin
                    idx_next = idx_inc;
                end
            end
        end
    end

    // chunk split
    always_comb begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        rem_less  = rem_start - TICK_W'(CHUNK_MAX);
        cmp       = '0;
        if (ev) begin
            if (rem_start > TICK_W'(GUARD_LIMIT)) begin
                cmp       = CMP_W'(CHUNK_MAX);
                rem_next  = rem_less;
                busy_next = 1'b1;
            end else if (rem_start > TICK_W'(CHUNK_MAX)) begin
                busy_next = 1'b1;
                if (rem_less < TICK_W'(RUNTIME_GUARD)) begin
                    cmp      = CMP_W'(SHORT_CHUNK);
                    rem_next = rem_start - TICK_W'(SHORT_CHUNK);
                end else begin
                    cmp      = CMP_W'(CHUNK_MAX);
                    rem_next = rem_less;
                end
            end else begin
                cmp       = rem_start[CMP_W-1:0];
                rem_next  = '0;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_low_reg <= 1'b0;
            rem_reg       <= '0;
            ft_reg        <= '0;
            idx_reg       <= '0;
            demux_reg     <= 1'b1;
        end else begin
            busy_reg      <= busy_next;
            phase_low_reg <= phase_low_next;
            rem_reg       <= rem_next;
            ft_reg        <= ft_next;
            idx_reg       <= idx_next;
            demux_reg     <= demux_next;
        end
    end

    assign idx_lookahead        = aresetn ? idx_next : '0;
    assign result.compare_value = cmp;
    assign result.low_phase     = phase_low_next;
    assign result.demux_reset   = demux_next;
    assign result.frame_restart = restart;

endmodule

@@ design/ppm_servo_frame_generator_core.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser = command, s_tdata = chan/value/flags
// m_        out  m_tvalid/m_tready  m_tdata = compare value and phase flags
// cfg_      in   cfg_wr_en          cfg_wr_data = channels_in_frame
//
// One item per cycle. Only a compare-match event yields a result item, in the
// cycle after it is taken; table writes yield none.
// The tables are prefetched at the channel index the sequencer moves to, so
// the registered memory read never stalls an event; a write in the same cycle
// is forwarded. Reset is synchronous (aresetn low); tables read as zero
// until written. The input stalls only while the output register is full
// and m_tready is low.
module ppm_servo_frame_generator_core
    import psfg_pkg::*;
#(
    parameter int MAX_CHANNELS  = 16,
    parameter int FRAME_UNIT    = 1757,
    parameter int STOP_PULSE    = 188,
    parameter int MIN_PULSE     = 375,
    parameter int MAX_PULSE     = 1500,
    parameter int RUNTIME_GUARD = 127
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // channel[3:0], value[14:4], failsafe_active[15],
                                         // servo_enable[16], zero fill
    input  logic [CMD_W-1:0]  s_tuser,   // command[1:0]

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // compare_value[7:0], low_phase[8], demux_reset[9],
                                         // frame_restart[10], zero fill

    input  logic              cfg_wr_en,
    input  logic [CIF_W-1:0]  cfg_wr_data
);

    logic [CIF_W-1:0]  cif_reg, cif_next;
    logic [TICK_W-1:0] frame_len_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    logic                      s_acc;
    cmd_t                      cmd;
    logic                      ev;
    tbl_wr_t                   tbl_wr;
    logic [IDX_W-1:0]          idx_lookahead;
    logic signed [VALUE_W-1:0] off_data;
    logic [FS_W-1:0]           fs_data;
    result_t                   seq_result;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign ev       = s_acc && (cmd == CMD_EVENT);

    assign tbl_wr.off_we = s_acc && (cmd == CMD_OFFSET);
    assign tbl_wr.fs_we  = s_acc && (cmd == CMD_FAILSAFE);
    assign tbl_wr.chan   = s_tdata[3:0];
    assign tbl_wr.value  = $signed(s_tdata[14:4]);

    // frame length follows the register with no extra latency
    assign cif_next = cfg_wr_en ? cfg_wr_data : cif_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cif_reg       <= CIF_RESET;
            frame_len_reg <= TICK_W'(FRAME_UNIT * int'(CIF_RESET));
        end else begin
            cif_reg       <= cif_next;
            frame_len_reg <= TICK_W'(FRAME_UNIT * int'(cif_next));
        end
    end

    psfg_tables #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_tables (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_index (idx_lookahead),
        .off_data (off_data),
        .fs_data  (fs_data)
    );

    psfg_sequencer #(
        .STOP_PULSE    (STOP_PULSE),
        .MIN_PULSE     (MIN_PULSE),
        .MAX_PULSE     (MAX_PULSE),
        .RUNTIME_GUARD (RUNTIME_GUARD)
    ) u_sequencer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ev            (ev),
        .fs_on         (s_tdata[15]),
        .enable        (s_tdata[16]),
        .cif           (cif_reg),
        .frame_len     (frame_len_reg),
        .off_data      (off_data),
        .fs_data       (fs_data),
        .idx_lookahead (idx_lookahead),
        .result        (seq_result)
    );

    // output register: loads on an event, drains on m_tready
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ev) begin
            m_valid_next = 1'b1;
            m_data_next  = seq_result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};

endmodule

@@ dv/ppm_servo_frame_checker.sv @@
`timescale 1ns / 100ps

module ppm_servo_frame_checker
    import psfg_pkg::*;
#(
    parameter int MAX_CHANNELS  = 16,
    parameter int FRAME_UNIT    = 1757,
    parameter int STOP_PULSE    = 188,
    parameter int MIN_PULSE     = 375,
    parameter int MAX_PULSE     = 1500,
    parameter int RUNTIME_GUARD = 127
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,   // channel, value, failsafe_active, servo_enable
    input  logic [CMD_W-1:0]  s_tuser,   // command

    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,   // compare_value, low_phase, demux_reset, frame_restart

    input  logic              cfg_wr_en,
    input  logic [CIF_W-1:0]  cfg_wr_data,

    output int                mismatch_count,
    output int                results_owed
);

    localparam int CENTER = MIN_PULSE + (MAX_PULSE - MIN_PULSE) / 2;
    localparam int FS_MAX = 255;
    localparam int TICK_MAX = 65535;

    logic [CIF_W-1:0]          chans_cfg;
    logic                      busy;
    logic                      in_low;
    logic                      demux_lvl;
    int unsigned               ticks_left;
    int unsigned               frame_acc;
    int unsigned               chan_at;
    logic signed [VALUE_W-1:0] offsets [MAX_CHANNELS];
    logic [FS_W-1:0]           fs_pos [FS_CHANNELS];
    result_t                   compare_items_due [$];
    int                        fails = 0;

    function automatic int unsigned clip16(input int unsigned v);
        return (v > TICK_MAX) ? TICK_MAX : v;
    endfunction

    // high time of one channel, stop pulse already taken off
    function automatic int unsigned servo_pulse(input int unsigned idx, input logic fs_on);
        int p;
        p = CENTER;
        if (fs_on && idx >= 1 && idx <= FS_CHANNELS && fs_pos[idx-1] != '0)
            p = p + int'(fs_pos[idx-1]) * 4 - FS_BIAS;
        else if (idx < MAX_CHANNELS)
            p = p + int'(offsets[idx]);
        if (p > MAX_PULSE)
            p = MAX_PULSE;
        else if (p < MIN_PULSE)
            p = MIN_PULSE;
        return int'(p - STOP_PULSE);
    endfunction

    function automatic void predict_item(input logic [CMD_W-1:0] cmd,
                                         input logic [CHAN_W-1:0] ch,
                                         input logic signed [VALUE_W-1:0] val,
                                         input logic fs_on,
                                         input logic enable,
                                         output bit produced,
                                         output result_t item);
        int unsigned frame_len;
        int unsigned cmp;
        logic        restart;
        produced = 1'b0;
        item     = '0;
        restart  = 1'b0;
        case (cmd)
            CMD_OFFSET: begin
                if (ch < MAX_CHANNELS)
                    offsets[ch] = val;
            end
            CMD_FAILSAFE: begin
                if (ch >= 1 && ch <= FS_CHANNELS) begin
                    if (val < 0)
                        fs_pos[ch-1] = '0;
                    else if (val > FS_MAX)
                        fs_pos[ch-1] = '1;
                    else
                        fs_pos[ch-1] = val[FS_W-1:0];
                end
            end
            CMD_EVENT: begin
                if (!busy) begin
                    if (in_low) begin
                        in_low = 1'b0;
                        if (chan_at == 0) begin
                            // sync gap fills the frame, never negative
                            frame_len  = FRAME_UNIT * chans_cfg;
                            ticks_left = (frame_len > frame_acc) ?
                                         clip16(frame_len - frame_acc) : 0;
                            frame_acc  = 0;
                            demux_lvl  = 1'b1;
                        end else if (chan_at > chans_cfg) begin
                            ticks_left = END_TICKS;
                        end else begin
                            ticks_left = servo_pulse(chan_at, fs_on);
                            frame_acc  = clip16(frame_acc + ticks_left);
                        end
                    end else begin
                        in_low     = 1'b1;
                        ticks_left = STOP_PULSE;
                        frame_acc  = clip16(frame_acc + ticks_left);
                        demux_lvl  = !enable;
                        chan_at    = chan_at + 1;
                        if (chan_at > chans_cfg + 1) begin
                            chan_at = 0;
                            restart = 1'b1;
                        end
                    end
                    busy = 1'b1;
                end
                // chunk split with the runtime guard on the tail
                if (ticks_left > CHUNK_MAX + RUNTIME_GUARD) begin
                    cmp        = CHUNK_MAX;
                    ticks_left = ticks_left - CHUNK_MAX;
                end else if (ticks_left > CHUNK_MAX) begin
                    if (ticks_left - CHUNK_MAX < RUNTIME_GUARD) begin
                        cmp        = CHUNK_MAX - RUNTIME_GUARD;
                        ticks_left = ticks_left - (CHUNK_MAX - RUNTIME_GUARD);
                    end else begin
                        cmp        = CHUNK_MAX;
                        ticks_left = ticks_left - CHUNK_MAX;
                    end
                end else begin
                    cmp        = ticks_left;
                    ticks_left = 0;
                    busy       = 1'b0;
                end
                item.compare_value = cmp[CMP_W-1:0];
                item.low_phase     = in_low;
                item.demux_reset   = demux_lvl;
                item.frame_restart = restart;
                produced = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void log_fault(input string msg);
        fails = fails + 1;
        if (fails <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin : track
        result_t want;
        result_t got;
        bit      produced;
        if (!aresetn) begin
            chans_cfg  = CIF_RESET;
            busy       = 1'b0;
            in_low     = 1'b0;
            demux_lvl  = 1'b1;
            ticks_left = 0;
            frame_acc  = 0;
            chan_at    = 0;
            foreach (offsets[i]) offsets[i] = '0;
            foreach (fs_pos[i]) fs_pos[i] = '0;
            compare_items_due.delete();
        end else begin
            if (cfg_wr_en)
                chans_cfg = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (compare_items_due.size() == 0) begin
                    log_fault($sformatf("unexpected item cmp %0d low %0b rst %0b restart %0b",
                                        got.compare_value, got.low_phase, got.demux_reset,
                                        got.frame_restart));
                end else begin
                    want = compare_items_due.pop_front();
                    if (got.compare_value != want.compare_value ||
                        got.low_phase != want.low_phase ||
                        got.demux_reset != want.demux_reset ||
                        got.frame_restart != want.frame_restart)
                        log_fault($sformatf({"mismatch exp/got: cmp %0d/%0d low %0b/%0b ",
                                             "rst %0b/%0b restart %0b/%0b"},
                                            want.compare_value, got.compare_value,
                                            want.low_phase, got.low_phase,
                                            want.demux_reset, got.demux_reset,
                                            want.frame_restart, got.frame_restart));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata[3:0], s_tdata[14:4], s_tdata[15], s_tdata[16],
                             produced, want);
                if (produced)
                    compare_items_due.push_back(want);
            end
        end
        results_owed   <= compare_items_due.size();
        mismatch_count <= fails;
    end

endmodule

@@ dv/ppm_servo_frame_generator_core_tb.sv @@
`timescale 1ns / 100ps

module ppm_servo_frame_generator_core_tb;
    import psfg_pkg::*;

    // command code the block has no use for; it must be swallowed silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int STALL_LIMIT     = 5000;  // cycles with no handshake at all
    localparam int LONG_HOLD       = 300;   // receiver back-pressure stretch
    localparam int PHASE_ITEMS     = 100;
    localparam int DRAIN_CYCLES    = 8;     // generous margin after the idle wait
    localparam int NUM_PHASES      = 5;

    localparam logic signed [VALUE_W-1:0] VAL_LO = -1024;
    localparam logic signed [VALUE_W-1:0] VAL_HI = 1023;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // channel[3:0], value[14:4], failsafe_active[15],
                                  // servo_enable[16], zero fill
    logic [CMD_W-1:0]  s_tuser;   // command[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;   // compare_value[7:0], low_phase[8], demux_reset[9],
                                  // frame_restart[10], zero fill
    logic              cfg_wr_en;
    logic [CIF_W-1:0]  cfg_wr_data;

    int mismatch_count;
    int results_owed;
    int send_idle_pct;   // chance in percent of a gap before an item
    logic fs_mode;       // current failsafe flag bias for random items

    ppm_servo_frame_generator_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ppm_servo_frame_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 2 ns period
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Gap length in cycles: zero unless a gap is drawn, then mostly short,
    // sometimes medium, now and then long.
    function automatic int idle_cycles(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;     // stretch with no idling
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Returns at the
    // edge of acceptance, so the next call can keep tvalid high.
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
                             input logic signed [VALUE_W-1:0] val, input logic fs_on,
                             input logic enable);
        int gap;
        gap = idle_cycles(send_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, enable, fs_on, val, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let every owed result drain, then wait out any table write still in
    // flight, so the register only changes while the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_channel_count(input logic [CIF_W-1:0] n);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly compare-match events so frames run deep; table writes land
    // mid-frame and hit channels being prefetched.
    task automatic random_item(output bit counted);
        int                        r;
        logic [CMD_W-1:0]          cmd;
        logic [CHAN_W-1:0]         ch;
        logic signed [VALUE_W-1:0] val;
        logic                      fs_on;
        r = $urandom_range(0, 99);
        if (r < 72)
            cmd = CMD_EVENT;
        else if (r < 86)
            cmd = CMD_OFFSET;
        else if (r < 97)
            cmd = CMD_FAILSAFE;
        else
            cmd = CMD_UNUSED;
        ch = CHAN_W'($urandom);
        if (cmd == CMD_FAILSAFE && $urandom_range(0, 4) != 0)
            ch = CHAN_W'($urandom_range(1, FS_CHANNELS));
        case ($urandom_range(0, 7))
            0: val = VAL_LO;
            1: val = VAL_HI;
            2: val = '0;
            3: val = VALUE_W'($urandom_range(0, 255));   // plausible failsafe position
            default: val = VALUE_W'($urandom);
        endcase
        if ($urandom_range(0, 19) == 0)
            fs_mode = ~fs_mode;
        fs_on = fs_mode ^ ($urandom_range(0, 9) == 0);
        push_item(cmd, ch, val, fs_on, $urandom_range(0, 9) != 0);
        counted = (cmd != CMD_UNUSED);
    endtask

    // Result side: random tready gaps in stretches of varying density,
    // plus long holds so the output register fills and the input stalls.
    initial begin : result_sink
        int hold_left;
        int sink_count;
        int recv_idle_pct;
        int stretch_left;
        int gap;
        bit took;
        m_tready      = 1'b0;
        hold_left     = 0;
        sink_count    = 0;
        recv_idle_pct = 0;
        stretch_left  = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            took = m_tvalid && m_tready;
            if (took)
                sink_count++;
            if (stretch_left == 0) begin
                stretch_left  = $urandom_range(50, 200);
                recv_idle_pct = pick_idle_pct();
            end else begin
                stretch_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (took && (sink_count == 40 || sink_count == 350))
                    gap = LONG_HOLD;
                else
                    gap = idle_cycles(recv_idle_pct);
                if (gap > 0) begin
                    hold_left = gap - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Ends the run if the channels go quiet for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        bit               counted;
        int               done;
        logic [CIF_W-1:0] phase_cif [NUM_PHASES];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_EVENT;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = CIF_RESET;
        send_idle_pct = 0;
        fs_mode       = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: offset extremes (both clamps), failsafe saturation both
        // ways, ignored failsafe channels, the unused command, then events
        // through a frame at the reset channel count.
        send_idle_pct = 20;
        push_item(CMD_OFFSET, 4'd0, VAL_HI, 1'b0, 1'b1);
        push_item(CMD_OFFSET, 4'd1, VAL_HI, 1'b0, 1'b1);
        push_item(CMD_OFFSET, 4'd2, VAL_LO, 1'b0, 1'b1);
        push_item(CMD_OFFSET, 4'd4, 11'sd300, 1'b0, 1'b1);
        push_item(CMD_OFFSET, 4'd15, -11'sd1, 1'b0, 1'b1);
        push_item(CMD_FAILSAFE, 4'd1, VAL_HI, 1'b0, 1'b1);     // saturates to 255
        push_item(CMD_FAILSAFE, 4'd2, VAL_LO, 1'b0, 1'b1);     // saturates to 0, unset
        push_item(CMD_FAILSAFE, 4'd5, 11'sd1, 1'b0, 1'b1);
        push_item(CMD_FAILSAFE, 4'd0, 11'sd50, 1'b0, 1'b1);    // outside failsafe range
        push_item(CMD_FAILSAFE, 4'd6, 11'sd77, 1'b0, 1'b1);    // outside failsafe range
        push_item(CMD_UNUSED, 4'd3, VAL_HI, 1'b1, 1'b1);
        repeat (7) push_item(CMD_EVENT, 4'd0, '0, 1'b1, 1'b0);
        repeat (7) push_item(CMD_EVENT, 4'hF, VAL_LO, 1'b0, 1'b1);

        // Random phases: single channel (sync gap shortfall is likely with
        // large offsets), zero channels, the maximum, one random count, and
        // back to the reset value.
        phase_cif[0] = CIF_W'(1);
        phase_cif[1] = CIF_W'(0);
        phase_cif[2] = CIF_W'(15);
        phase_cif[3] = CIF_W'($urandom_range(2, 14));
        phase_cif[4] = CIF_RESET;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_channel_count(phase_cif[ph]);
            fs_mode = $urandom_range(0, 1);
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (done % 40 == 0)
                    send_idle_pct = pick_idle_pct();
                random_item(counted);
                if (counted)
                    done++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/psfg_pkg.sv
design/psfg_tables.sv
design/psfg_sequencer.sv
design/ppm_servo_frame_generator_core.sv
dv/ppm_servo_frame_checker.sv
dv/ppm_servo_frame_generator_core_tb.sv
